>>> src/dmds_pkg.sv
// Shared types, constants and helpers for the dual motor duty slew limiter.
// No dependencies; every other file refers to it by scoped names.
package dmds_pkg;

  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned VAL_W    = 17;
  localparam int unsigned REQ_W    = 18;
  localparam int unsigned KIND_W   = 3;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 16'd10000;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET   = 3'd0,
    KIND_FWD   = 3'd1,
    KIND_TURN  = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_BRAKE = 3'd4,
    KIND_TICK  = 3'd5
  } kind_t;

  // Per-wheel command as seen by one wheel's update logic
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [REQ_W-1:0]  req;
    logic [DUTY_W-1:0]        limit;
  } wheel_cmd_t;

  typedef struct packed {
    logic [DUTY_W-1:0] applied;
    logic [DUTY_W-1:0] goal;
  } wheel_state_t;

  // Saturate a signed request to 0..DUTY_MAX
  function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [REQ_W-1:0] v);
    logic signed [REQ_W-1:0] max_s;
    max_s = $signed({{(REQ_W-DUTY_W){1'b0}}, DUTY_MAX});
    if (v < 0) begin
      sat_duty = '0;
    end else if (v > max_s) begin
      sat_duty = DUTY_MAX;
    end else begin
      sat_duty = v[DUTY_W-1:0];
    end
  endfunction

endpackage

>>> src/dmds_in_if.sv
// Command channel: valid/ready handshake carrying one command item.
// Depends on dmds_pkg for field widths.
interface dmds_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [dmds_pkg::KIND_W-1:0]           kind;
  logic signed [dmds_pkg::VAL_W-1:0]     first_value;
  logic signed [dmds_pkg::VAL_W-1:0]     second_value;

  modport source (output valid, kind, first_value, second_value, input ready);
  modport sink   (input valid, kind, first_value, second_value, output ready);
endinterface

>>> src/dmds_out_if.sv
// Result channel: valid/ready handshake carrying duties and direction levels.
// Depends on dmds_pkg for field widths.
interface dmds_out_if;
  logic                          valid;
  logic                          ready;
  logic [dmds_pkg::DUTY_W-1:0]   left_duty;
  logic [dmds_pkg::DUTY_W-1:0]   right_duty;
  logic                          left_dir_level;
  logic                          right_dir_level;
  logic                          braking;

  modport source (output valid, left_duty, right_duty, left_dir_level,
                  right_dir_level, braking, input ready);
  modport sink   (input valid, left_duty, right_duty, left_dir_level,
                  right_dir_level, braking, output ready);
endinterface

>>> src/dmds_cfg_if.sv
// Configuration write channel carrying the acceleration limit.
// Depends on dmds_pkg for the data width.
interface dmds_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dmds_pkg::DUTY_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> src/dmds_wheel.sv
// Next applied and goal duty for one wheel, purely combinational.
// Depends on dmds_pkg for types and the saturation helper.
module dmds_wheel (
  input  dmds_pkg::wheel_cmd_t   cmd,
  input  dmds_pkg::wheel_state_t cur,
  output dmds_pkg::wheel_state_t nxt
);

  localparam int unsigned RW = dmds_pkg::REQ_W;

  logic signed [RW-1:0] cur_s;
  logic signed [RW-1:0] goal_s;
  logic signed [RW-1:0] lim_s;
  logic signed [RW-1:0] delta;
  logic [dmds_pkg::DUTY_W-1:0] req_sat;
  logic [dmds_pkg::DUTY_W-1:0] slewed;

  assign cur_s   = $signed({{(RW-dmds_pkg::DUTY_W){1'b0}}, cur.applied});
  assign goal_s  = $signed({{(RW-dmds_pkg::DUTY_W){1'b0}}, cur.goal});
  assign lim_s   = $signed({{(RW-dmds_pkg::DUTY_W){1'b0}}, cmd.limit});
  assign delta   = goal_s - cur_s;
  assign req_sat = dmds_pkg::sat_duty(cmd.req);

  // Step toward the goal by at most the limit
  always_comb begin
    if (delta > lim_s) begin
      slewed = dmds_pkg::sat_duty(cur_s + lim_s);
    end else if (delta < -lim_s) begin
      slewed = dmds_pkg::sat_duty(cur_s - lim_s);
    end else begin
      slewed = cur.goal;
    end
  end

  always_comb begin
    nxt = cur;
    case (dmds_pkg::kind_t'(cmd.kind))
      dmds_pkg::KIND_SET, dmds_pkg::KIND_FWD, dmds_pkg::KIND_TURN: begin
        nxt.goal = req_sat;
        if (cmd.limit == '0) nxt.applied = req_sat;
      end
      dmds_pkg::KIND_STOP, dmds_pkg::KIND_BRAKE: begin
        nxt.goal    = '0;
        nxt.applied = '0;
      end
      dmds_pkg::KIND_TICK: begin
        if (cmd.limit != '0) nxt.applied = slewed;
      end
      default: nxt = cur;
    endcase
  end

endmodule

>>> src/dual_motor_duty_slew_limiter_unit.sv
// Dual motor duty slew limiter: top level.
// Accepted items pass the input register, then the result register.
// Throughput: one command item per cycle while results are taken, set by
// the single pass through the per-wheel update logic between them.
// Reset (rst_n low, synchronous): duties, goals and limit clear to zero,
// forward mode, both stages empty. Depends on dmds_pkg, the three channel
// interfaces and dmds_wheel.
module dual_motor_duty_slew_limiter_unit (
  input  logic              clk,
  input  logic              rst_n,
  dmds_in_if.sink           in_chan,
  dmds_out_if.source        out_chan,
  dmds_cfg_if.sink          cfg_chan
);

  localparam int unsigned RW = dmds_pkg::REQ_W;

  // Input register stage
  logic                               in_v_r;
  logic [dmds_pkg::KIND_W-1:0]        kind_r;
  logic signed [dmds_pkg::VAL_W-1:0]  a_r;
  logic signed [dmds_pkg::VAL_W-1:0]  b_r;

  // Block state
  logic [dmds_pkg::DUTY_W-1:0]        limit_r;
  dmds_pkg::wheel_state_t             left_r, right_r;
  dmds_pkg::wheel_state_t             left_nxt, right_nxt;
  logic                               brake_r, brake_nxt;

  // Result register
  logic                               out_v_r;
  logic [dmds_pkg::DUTY_W-1:0]        left_duty_r, right_duty_r;
  logic                               brake_out_r;

  logic                               advance;
  logic signed [RW-1:0]               a_s, b_s;
  logic signed [RW-1:0]               left_req, right_req;
  dmds_pkg::wheel_cmd_t               left_cmd, right_cmd;

  // The result register frees when empty or taken; the input stage moves
  // into it then, so a new item can enter every cycle if not stalled.
  assign advance        = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready  = !in_v_r || advance;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  // Hold the payload while the stage is stalled
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      kind_r <= in_chan.kind;
      a_r    <= in_chan.first_value;
      b_r    <= in_chan.second_value;
    end
  end

  // Per-wheel requests: turn splits the base speed by the difference
  assign a_s = RW'(a_r);
  assign b_s = RW'(b_r);

  always_comb begin
    left_req  = a_s;
    right_req = a_s;
    case (dmds_pkg::kind_t'(kind_r))
      dmds_pkg::KIND_SET: begin
        right_req = b_s;
      end
      dmds_pkg::KIND_TURN: begin
        left_req  = a_s - b_s;
        right_req = a_s + b_s;
      end
      default: begin
        left_req  = a_s;
        right_req = a_s;
      end
    endcase
  end

  assign left_cmd  = '{kind: kind_r, req: left_req,  limit: limit_r};
  assign right_cmd = '{kind: kind_r, req: right_req, limit: limit_r};

  dmds_wheel u_left  (.cmd(left_cmd),  .cur(left_r),  .nxt(left_nxt));
  dmds_wheel u_right (.cmd(right_cmd), .cur(right_r), .nxt(right_nxt));

  // Brake sets brake mode; forward and turn drop it
  always_comb begin
    case (dmds_pkg::kind_t'(kind_r))
      dmds_pkg::KIND_FWD, dmds_pkg::KIND_TURN: brake_nxt = 1'b0;
      dmds_pkg::KIND_BRAKE:                    brake_nxt = 1'b1;
      default:                                 brake_nxt = brake_r;
    endcase
  end

  // Commit state as an item leaves the input stage; limit on config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
      left_r  <= '0;
      right_r <= '0;
      brake_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) limit_r <= cfg_chan.data;
      if (advance) begin
        left_r  <= left_nxt;
        right_r <= right_nxt;
        brake_r <= brake_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_chan.ready) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_duty_r  <= left_nxt.applied;
      right_duty_r <= right_nxt.applied;
      brake_out_r  <= brake_nxt;
    end
  end

  assign out_chan.valid           = out_v_r;
  assign out_chan.left_duty       = left_duty_r;
  assign out_chan.right_duty      = right_duty_r;
  assign out_chan.left_dir_level  = !brake_out_r;
  assign out_chan.right_dir_level = 1'b0;
  assign out_chan.braking         = brake_out_r;

endmodule

>>> bench/dual_motor_duty_slew_limiter_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for dual_motor_duty_slew_limiter_unit: commands, ramp ticks
// and limit writes go in, every result is checked against a cycle-free predictor.
// Depends on dmds_pkg, the three channel interfaces and the block under test.
module dual_motor_duty_slew_limiter_unit_tb;

  // Kinds six and seven have no meaning; the block must pass them through untouched
  localparam logic [dmds_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [dmds_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;

  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int WATCHDOG_MAX  = 5000;  // cycles without any handshake
  localparam int SETTLE_CYCLES = 6;     // extra wait beyond the block's latency
  localparam int PHASE_ITEMS   = 180;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [dmds_pkg::DUTY_W-1:0] left_duty;
    logic [dmds_pkg::DUTY_W-1:0] right_duty;
    logic                        left_level;
    logic                        right_level;
    logic                        braking;
  } duty_result_t;

  // Tracks the duties, goals and mode the block ought to hold, and the
  // results that accepted commands have still to produce.
  class duty_scoreboard;
    logic [dmds_pkg::DUTY_W-1:0] slew_limit;
    logic [dmds_pkg::DUTY_W-1:0] left_applied, right_applied;
    logic [dmds_pkg::DUTY_W-1:0] left_goal, right_goal;
    bit                          in_brake;
    duty_result_t                expected_q[$];
    int                          mismatches;

    function new();
      slew_limit    = '0;
      left_applied  = '0;
      right_applied = '0;
      left_goal     = '0;
      right_goal    = '0;
      in_brake      = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_limit(logic [dmds_pkg::DUTY_W-1:0] v);
      slew_limit = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [dmds_pkg::DUTY_W-1:0] clamp_duty(int v);
      if (v < 0) return '0;
      if (v > int'(dmds_pkg::DUTY_MAX)) return dmds_pkg::DUTY_MAX;
      return v[dmds_pkg::DUTY_W-1:0];
    endfunction

    // Move one wheel toward its goal by no more than the limit
    function logic [dmds_pkg::DUTY_W-1:0] step_toward(
        logic [dmds_pkg::DUTY_W-1:0] cur, logic [dmds_pkg::DUTY_W-1:0] goal);
      int lim;
      int delta;
      lim   = int'(slew_limit);
      delta = int'(goal) - int'(cur);
      if (delta > lim) return clamp_duty(int'(cur) + lim);
      if (delta < -lim) return clamp_duty(int'(cur) - lim);
      return goal;
    endfunction

    function void demand(int l, int r);
      left_goal  = clamp_duty(l);
      right_goal = clamp_duty(r);
      if (slew_limit == 0) begin
        left_applied  = left_goal;
        right_applied = right_goal;
      end
    endfunction

    function void note_command(logic [dmds_pkg::KIND_W-1:0] kind,
                               logic signed [dmds_pkg::VAL_W-1:0] a,
                               logic signed [dmds_pkg::VAL_W-1:0] b);
      int           ai;
      int           bi;
      duty_result_t res;
      ai = a;
      bi = b;
      case (kind)
        dmds_pkg::KIND_SET: demand(ai, bi);
        dmds_pkg::KIND_FWD: begin
          in_brake = 1'b0;
          demand(ai, ai);
        end
        dmds_pkg::KIND_TURN: begin
          in_brake = 1'b0;
          demand(ai - bi, ai + bi);
        end
        dmds_pkg::KIND_STOP, dmds_pkg::KIND_BRAKE: begin
          left_goal     = '0;
          right_goal    = '0;
          left_applied  = '0;
          right_applied = '0;
          if (kind == dmds_pkg::KIND_BRAKE) in_brake = 1'b1;
        end
        dmds_pkg::KIND_TICK: begin
          if (slew_limit != 0) begin
            left_applied  = step_toward(left_applied, left_goal);
            right_applied = step_toward(right_applied, right_goal);
          end
        end
        default: ;
      endcase
      res.left_duty   = left_applied;
      res.right_duty  = right_applied;
      res.left_level  = !in_brake;
      res.right_level = 1'b0;
      res.braking     = in_brake;
      expected_q.push_back(res);
    endfunction

    function void check_result(duty_result_t got);
      duty_result_t exp;
      if (expected_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("ERROR: result item with nothing pending: l=%0d r=%0d",
                   got.left_duty, got.right_duty);
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.left_duty !== exp.left_duty || got.right_duty !== exp.right_duty ||
          got.left_level !== exp.left_level || got.right_level !== exp.right_level ||
          got.braking !== exp.braking) begin
        if (mismatches < MAX_REPORTS)
          $display({"ERROR at %0t: expected l=%0d r=%0d ldir=%0b rdir=%0b brk=%0b,",
                    " got l=%0d r=%0d ldir=%0b rdir=%0b brk=%0b"},
                   $realtime, exp.left_duty, exp.right_duty, exp.left_level,
                   exp.right_level, exp.braking, got.left_duty, got.right_duty,
                   got.left_level, got.right_level, got.braking);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dmds_in_if  in_if();
  dmds_out_if out_if();
  dmds_cfg_if cfg_if();

  dual_motor_duty_slew_limiter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  duty_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;
  int quiet_cycles;

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus a long hold-off on request. The
  // hold-off is counted here so the sender carries on offering items meanwhile.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sample both channels on the edge; check the result before noting the
  // command, since a result can never belong to a command of the same edge.
  always @(posedge clk) begin
    duty_result_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.left_duty   = out_if.left_duty;
        got.right_duty  = out_if.right_duty;
        got.left_level  = out_if.left_dir_level;
        got.right_level = out_if.right_dir_level;
        got.braking     = out_if.braking;
        sb.check_result(got);
      end
      if (in_if.valid && in_if.ready)
        sb.note_command(in_if.kind, in_if.first_value, in_if.second_value);
    end
  end

  // Watchdog: give up once nothing has moved on any channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("ERROR: no handshake for %0d cycles", WATCHDOG_MAX);
        $display("dual_motor_duty_slew_limiter_unit_tb: done, errors");
        $finish;
      end
    end
  end

  // Offer one command item and hold it until the block takes it. An optional
  // idle gap comes first, so valid is never dropped and raised in one step.
  task automatic send_cmd(input logic [dmds_pkg::KIND_W-1:0] k,
                          input logic signed [dmds_pkg::VAL_W-1:0] a,
                          input logic signed [dmds_pkg::VAL_W-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= k;
    in_if.first_value  <= a;
    in_if.second_value <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the limit only once the block has gone idle
  task automatic write_limit(input logic [dmds_pkg::DUTY_W-1:0] v);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_limit(v);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly in-range duties; now and then out of range, extremes or any bit pattern
  function automatic logic signed [dmds_pkg::VAL_W-1:0] rand_duty();
    logic signed [dmds_pkg::VAL_W-1:0] v;
    int                                sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3, 4: v = dmds_pkg::VAL_W'($urandom_range(0, 10000));
      5: v = dmds_pkg::VAL_W'($urandom_range(0, 12000)) - dmds_pkg::VAL_W'(1000);
      6: v = dmds_pkg::VAL_W'($urandom_range(0, 400));
      7: v = dmds_pkg::VAL_W'($urandom);
      default: begin
        case ($urandom_range(5))
          0: v = 17'sh10000;
          1: v = 17'sh0FFFF;
          2: v = 17'sd10000;
          3: v = 17'sd10001;
          4: v = -17'sd1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_random_cmd();
    logic [dmds_pkg::KIND_W-1:0]       k;
    logic signed [dmds_pkg::VAL_W-1:0] a;
    logic signed [dmds_pkg::VAL_W-1:0] b;
    int                                r;
    int                                d;
    r = $urandom_range(99);
    if (r < 38)      k = dmds_pkg::KIND_TICK;
    else if (r < 52) k = dmds_pkg::KIND_SET;
    else if (r < 64) k = dmds_pkg::KIND_FWD;
    else if (r < 76) k = dmds_pkg::KIND_TURN;
    else if (r < 82) k = dmds_pkg::KIND_STOP;
    else if (r < 88) k = dmds_pkg::KIND_BRAKE;
    else if (r < 91) k = KIND_SPARE_A;
    else if (r < 94) k = KIND_SPARE_B;
    else             k = dmds_pkg::KIND_TICK;
    a = rand_duty();
    if (k == dmds_pkg::KIND_TURN && $urandom_range(1)) begin
      // keep most turns gentle so both wheels stay in range
      d = $urandom_range(0, 4000);
      d = d - 2000;
      b = dmds_pkg::VAL_W'(d);
    end else begin
      b = rand_duty();
    end
    send_cmd(k, a, b);
  endtask

  initial begin
    logic [dmds_pkg::DUTY_W-1:0] limits[6];

    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.kind          = dmds_pkg::KIND_SET;
    in_if.first_value   = '0;
    in_if.second_value  = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = '0;
    hold_req            = 1'b0;
    hold_left           = 0;
    quiet_cycles        = 0;
    send_idle_pct       = 7;
    recv_idle_pct       = 56;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, limit still at its reset value of zero: saturation at
    // both ends, immediate effect, tick doing nothing, brake and stop modes
    send_cmd(dmds_pkg::KIND_SET, 17'sh0FFFF, 17'sh10000);
    send_cmd(dmds_pkg::KIND_SET, -17'sd1, 17'sd10001);
    send_cmd(dmds_pkg::KIND_SET, 17'sd10000, 17'sd9999);
    send_cmd(dmds_pkg::KIND_TICK, 17'sd0, 17'sd0);
    send_cmd(dmds_pkg::KIND_FWD, 17'sd5000, 17'sh1ABCD);
    send_cmd(dmds_pkg::KIND_TURN, 17'sd5000, 17'sd6000);
    send_cmd(dmds_pkg::KIND_TURN, 17'sd3000, 17'sh10000);
    send_cmd(dmds_pkg::KIND_STOP, 17'sh15555, 17'sh0AAAA);
    send_cmd(dmds_pkg::KIND_BRAKE, 17'sd777, 17'sd888);
    // set while braking keeps brake mode; stop does not leave it either
    send_cmd(dmds_pkg::KIND_SET, 17'sd1234, 17'sd4321);
    send_cmd(dmds_pkg::KIND_STOP, 17'sd0, 17'sd0);
    send_cmd(KIND_SPARE_A, 17'sh1FFFF, 17'sh1FFFF);
    send_cmd(dmds_pkg::KIND_TURN, 17'sd0, 17'sd0);
    send_cmd(dmds_pkg::KIND_BRAKE, 17'sd0, 17'sd0);
    send_cmd(dmds_pkg::KIND_FWD, 17'sh0FFFF, 17'sd0);
    send_cmd(KIND_SPARE_B, 17'sh10000, 17'sd1);

    // Now ramp: goals set, applied duties move toward them only on ticks
    write_limit(16'd3000);
    send_cmd(dmds_pkg::KIND_SET, 17'sd10000, 17'sd2000);
    send_cmd(dmds_pkg::KIND_TICK, 17'sd0, 17'sd0);
    send_cmd(dmds_pkg::KIND_TICK, 17'sd0, 17'sd0);
    send_cmd(dmds_pkg::KIND_TICK, 17'sd0, 17'sd0);
    send_cmd(dmds_pkg::KIND_FWD, 17'sd0, 17'sd0);
    send_cmd(dmds_pkg::KIND_TICK, 17'sd0, 17'sd0);
    send_cmd(dmds_pkg::KIND_TURN, 17'sd6000, 17'sd100);
    send_cmd(dmds_pkg::KIND_TICK, 17'sd0, 17'sd0);
    send_cmd(dmds_pkg::KIND_BRAKE, 17'sd0, 17'sd0);

    // Random phases, each under its own limit, extremes among them
    limits[0] = 16'hFFFF;
    limits[1] = 16'd1;
    limits[2] = dmds_pkg::DUTY_W'($urandom_range(2, 2000));
    limits[3] = 16'd0;
    limits[4] = 16'd250;
    limits[5] = dmds_pkg::DUTY_W'($urandom);

    for (int p = 0; p < 6; p++) begin
      // receiver idles heavily first, then the sender does, then neither
      if (p < 2) begin
        send_idle_pct = 7;
        recv_idle_pct = 56;
      end else if (p < 4) begin
        send_idle_pct = 56;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_limit(limits[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold the receiver off while commands keep coming, to fill the block
        if (p == 1 && i == 60) hold_req = 1'b1;
        // pause the sender until everything outstanding has come back
        if (p == 3 && i == 90) drain();
        send_random_cmd();
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("dual_motor_duty_slew_limiter_unit_tb: done, clean");
    end else begin
      $display("dual_motor_duty_slew_limiter_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
